>>> src/battery_mode_controller_defines.svh
// ----------------------------------------------------------------------------
// Battery mode controller assertion macros
// Shared assertion helpers for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef BATTERY_MODE_CONTROLLER_DEFINES_SVH
`define BATTERY_MODE_CONTROLLER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define BMC_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define BMC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bmc_pkg.sv
// ----------------------------------------------------------------------------
// Battery mode controller package
// Modes, reason codes, contactor commands, event codes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package bmc_pkg;

    localparam logic [2:0] MODE_STANDBY  = 3'd0;
    localparam logic [2:0] MODE_DRIVE    = 3'd1;
    localparam logic [2:0] MODE_HEATING  = 3'd2;
    localparam logic [2:0] MODE_CHARGING = 3'd3;
    localparam logic [2:0] MODE_EMPTY    = 3'd4;
    localparam logic [2:0] MODE_OVERTEMP = 3'd5;
    localparam logic [2:0] MODE_ILLEGAL  = 3'd6;
    localparam logic [2:0] MODE_CRITICAL = 3'd7;

    localparam logic [3:0] WHY_NONE     = 4'd0;
    localparam logic [3:0] WHY_COLD     = 4'd1;
    localparam logic [3:0] WHY_HOT      = 4'd2;
    localparam logic [3:0] WHY_EMPTY    = 4'd3;
    localparam logic [3:0] WHY_FULL     = 4'd4;
    localparam logic [3:0] WHY_MODULE   = 4'd5;
    localparam logic [3:0] WHY_SHUNT    = 4'd6;
    localparam logic [3:0] WHY_CHARGING = 4'd7;
    localparam logic [3:0] WHY_ILLEGAL  = 4'd8;
    localparam logic [3:0] WHY_CRITICAL = 4'd9;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_INHIBIT = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_DRIVE   = 3'd3;
    localparam logic [2:0] CMD_CHARGE  = 3'd4;

    localparam logic [3:0] EV_TOO_COLD   = 4'd0;
    localparam logic [3:0] EV_TEMP_OK    = 4'd1;
    localparam logic [3:0] EV_TOO_HOT    = 4'd2;
    localparam logic [3:0] EV_EMPTY      = 4'd3;
    localparam logic [3:0] EV_NOT_EMPTY  = 4'd4;
    localparam logic [3:0] EV_FULL       = 4'd5;
    localparam logic [3:0] EV_IMBALANCED = 4'd6;
    localparam logic [3:0] EV_BALANCED   = 4'd7;
    localparam logic [3:0] EV_IGN_ON     = 4'd8;
    localparam logic [3:0] EV_IGN_OFF    = 4'd9;
    localparam logic [3:0] EV_CHG_START  = 4'd10;
    localparam logic [3:0] EV_CHG_END    = 4'd11;
    localparam logic [3:0] EV_MOD_DEAD   = 4'd12;
    localparam logic [3:0] EV_MODS_OK    = 4'd13;
    localparam logic [3:0] EV_SHUNT_DEAD = 4'd14;
    localparam logic [3:0] EV_SHUNT_OK   = 4'd15;

    localparam int OUT_COUNT_WIDTH = 16;

    typedef struct packed {
        logic [3:0] event_code;
        logic       ignition_on;
        logic       charge_enabled;
        logic       any_cell_full;
        logic       any_cell_empty;
        logic       battery_too_hot;
        logic       too_cold_for_charge;
        logic       packs_imbalanced;
        logic       contactors_held;
        logic       shunt_dead;
        logic       modules_alive;
    } t_event;

    typedef struct packed {
        logic [2:0]  mode;
        logic        charge_block;
        logic [3:0]  charge_block_why;
        logic        drive_block;
        logic [3:0]  drive_block_why;
        logic        heater_drive;
        logic [2:0]  contactor_cmd;
        logic        weld_check_pulse;
        logic        limit_recalc_pulse;
        logic        shunt_reset_pulse;
        logic        illegal_flag;
        logic [15:0] bad_event_count;
    } t_result;

    // Kept mode and inhibit state, excluding the counter.
    typedef struct packed {
        logic [2:0] mode;
        logic       chg;
        logic [3:0] chg_why;
        logic       drv;
        logic [3:0] drv_why;
        logic       heater;
        logic       illegal;
    } t_ctl_state;

    // Per-event actions from the decoder besides the new state.
    typedef struct packed {
        logic [2:0] cmd;
        logic       weld;
        logic       recalc;
        logic       sreset;
        logic       bad;
    } t_actions;

endpackage
`default_nettype wire

>>> src/bmc_if.sv
// ----------------------------------------------------------------------------
// Battery mode controller channel interfaces
// Valid/ready channels for event requests and result requests.
// ----------------------------------------------------------------------------
`default_nettype none
interface bmc_event_if;
    import bmc_pkg::*;
    logic   valid;
    logic   ready;
    t_event data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bmc_result_if;
    import bmc_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/battery_mode_controller.sv
// ----------------------------------------------------------------------------
// Battery mode controller
// Eight-mode battery management controller with inhibit and fault tracking.
// ----------------------------------------------------------------------------
// Each accepted event request is decoded in the cycle it arrives and its
// result request appears on the output in the next cycle; one event can be
// taken every clock as long as the output side keeps up, since the single
// output register is refilled in the same cycle it is drained. The
// combinational next-state decode updates the mode register on each accept.
`default_nettype none
`include "battery_mode_controller_defines.svh"
module battery_mode_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    bmc_event_if.sink     i_event,
    bmc_result_if.source  o_result
);
    import bmc_pkg::*;

    t_ctl_state             r_state, n_state;
    t_actions               w_act;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_out_valid;
    t_result                r_out;
    logic                   w_accept;

    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

    bmc_decode u_decode (
        .i_cur (r_state),
        .i_ev  (i_event.data),
        .o_nxt (n_state),
        .o_act (w_act)
    );

    // Accept whenever the output register is empty or drains this cycle.
    assign i_event.ready = !r_out_valid || o_result.ready;
    assign w_accept      = i_event.valid && i_event.ready;

    // Saturating count of invalid events.
    always_comb begin
        n_count = r_count;
        if (w_act.bad && r_count != CountMax) n_count = r_count + 1'b1;
    end

    // Kept state and counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                r_count <= n_count;
            end
            if (w_accept) r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.mode               <= n_state.mode;
            r_out.charge_block       <= n_state.chg;
            r_out.charge_block_why   <= n_state.chg_why;
            r_out.drive_block        <= n_state.drv;
            r_out.drive_block_why    <= n_state.drv_why;
            r_out.heater_drive       <= n_state.heater;
            r_out.contactor_cmd      <= w_act.cmd;
            r_out.weld_check_pulse   <= w_act.weld;
            r_out.limit_recalc_pulse <= w_act.recalc;
            r_out.shunt_reset_pulse  <= w_act.sreset;
            r_out.illegal_flag       <= n_state.illegal;
            if (COUNT_WIDTH >= OUT_COUNT_WIDTH) begin
                r_out.bad_event_count <= OUT_COUNT_WIDTH'(n_count);
            end else begin
                r_out.bad_event_count <= OUT_COUNT_WIDTH'({{OUT_COUNT_WIDTH{1'b0}}, n_count});
            end
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // Checks on the kept state.
    `BMC_ASSERT_NEXT(a_result_after_accept, i_clk, i_rst_n, w_accept, o_result.valid,
        "result missing after accepted event")
    `BMC_ASSERT_IMPL(a_illegal_mode_flag, i_clk, i_rst_n,
        r_state.mode == MODE_ILLEGAL, r_state.illegal, "illegal mode without flag")
    `BMC_ASSERT_IMPL(a_charge_why, i_clk, i_rst_n,
        !r_state.chg, r_state.chg_why == WHY_NONE, "charge reason without inhibit")
    `BMC_ASSERT_IMPL(a_drive_why, i_clk, i_rst_n,
        !r_state.drv, r_state.drv_why == WHY_NONE, "drive reason without inhibit")

endmodule
`default_nettype wire

>>> src/bmc_decode.sv
// ----------------------------------------------------------------------------
// Battery mode controller next-state decode
// Applies the current mode's safety actions, then the event's transition rule.
// ----------------------------------------------------------------------------
`default_nettype none
module bmc_decode (
    input  wire bmc_pkg::t_ctl_state i_cur,
    input  wire bmc_pkg::t_event     i_ev,
    output bmc_pkg::t_ctl_state      o_nxt,
    output bmc_pkg::t_actions        o_act
);
    import bmc_pkg::*;

    t_ctl_state s;
    t_actions   a;
    logic ign, chen, full, empty, hot, cold, imb, held, sdead, alive;

    assign ign   = i_ev.ignition_on;
    assign chen  = i_ev.charge_enabled;
    assign full  = i_ev.any_cell_full;
    assign empty = i_ev.any_cell_empty;
    assign hot   = i_ev.battery_too_hot;
    assign cold  = i_ev.too_cold_for_charge;
    assign imb   = i_ev.packs_imbalanced;
    assign held  = i_ev.contactors_held;
    assign sdead = i_ev.shunt_dead;
    assign alive = i_ev.modules_alive;

    // Flat decode of mode and event.
    always_comb begin
        s = i_cur;
        a = '0;
        a.cmd = CMD_NONE;
        case (i_cur.mode)
            MODE_STANDBY: begin
                s.heater = 1'b0;
                a.weld = 1'b1;
                case (i_ev.event_code)
                    EV_TOO_COLD: begin s.chg = 1'b1; s.chg_why = WHY_COLD; end
                    EV_TEMP_OK: if (!full) begin s.chg = 1'b0; s.chg_why = WHY_NONE; end
                    EV_TOO_HOT: begin
                        s.drv = 1'b1; s.drv_why = WHY_HOT;
                        s.chg = 1'b1; s.chg_why = WHY_HOT; s.mode = MODE_OVERTEMP;
                    end
                    EV_EMPTY: begin s.drv = 1'b1; s.drv_why = WHY_EMPTY; s.mode = MODE_EMPTY; end
                    EV_NOT_EMPTY: if (!hot) begin s.chg = 1'b0; s.chg_why = WHY_NONE; end
                    EV_FULL: begin s.chg = 1'b1; s.chg_why = WHY_FULL; end
                    EV_IMBALANCED: a.cmd = CMD_INHIBIT;
                    EV_BALANCED: a.cmd = CMD_RELEASE;
                    EV_IGN_ON: begin
                        if (held) a.cmd = CMD_DRIVE;
                        s.mode = MODE_DRIVE;
                    end
                    EV_CHG_START: begin
                        if (held) a.cmd = CMD_CHARGE;
                        s.drv = 1'b1; s.drv_why = WHY_CHARGING;
                        if (cold) begin
                            s.heater = 1'b1; s.chg = 1'b1; s.chg_why = WHY_COLD;
                            s.mode = MODE_HEATING;
                        end else begin
                            s.mode = MODE_CHARGING;
                        end
                    end
                    EV_IGN_OFF, EV_CHG_END: a.bad = 1'b1;
                    EV_MOD_DEAD: begin
                        s.chg = 1'b1; s.chg_why = WHY_MODULE;
                        s.drv = 1'b1; s.drv_why = WHY_MODULE; s.mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        s.chg = 1'b1; s.chg_why = WHY_SHUNT;
                        s.drv = 1'b1; s.drv_why = WHY_SHUNT; s.mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_DRIVE: begin
                s.drv = 1'b0; s.drv_why = WHY_NONE; s.heater = 1'b0;
                case (i_ev.event_code)
                    EV_TOO_COLD: begin s.chg = 1'b1; s.chg_why = WHY_COLD; end
                    EV_TEMP_OK: if (!full) begin s.chg = 1'b0; s.chg_why = WHY_NONE; end
                    EV_TOO_HOT: begin
                        s.drv = 1'b1; s.drv_why = WHY_HOT;
                        s.chg = 1'b1; s.chg_why = WHY_HOT; s.mode = MODE_OVERTEMP;
                    end
                    EV_EMPTY: begin s.drv = 1'b1; s.drv_why = WHY_EMPTY; s.mode = MODE_EMPTY; end
                    EV_NOT_EMPTY: if (!cold) begin s.chg = 1'b0; s.chg_why = WHY_NONE; end
                    EV_FULL: begin s.chg = 1'b1; s.chg_why = WHY_FULL; end
                    EV_IGN_ON, EV_CHG_END: a.bad = 1'b1;
                    EV_IGN_OFF: begin
                        if (imb) a.cmd = CMD_INHIBIT;
                        s.mode = MODE_STANDBY;
                    end
                    EV_CHG_START: begin
                        s.drv = 1'b1; s.drv_why = WHY_CHARGING;
                        if (held) begin
                            s.chg = 1'b1; s.chg_why = WHY_ILLEGAL;
                            s.illegal = 1'b1; s.mode = MODE_ILLEGAL;
                        end else begin
                            s.mode = MODE_CHARGING;
                        end
                    end
                    EV_MOD_DEAD: begin s.chg = 1'b1; s.chg_why = WHY_MODULE; end
                    EV_SHUNT_DEAD: begin s.chg = 1'b1; s.chg_why = WHY_SHUNT; end
                    default: ;
                endcase
            end
            MODE_HEATING: begin
                s.chg = 1'b1; s.chg_why = WHY_COLD;
                s.drv = 1'b1; s.drv_why = WHY_CHARGING; s.heater = 1'b1;
                case (i_ev.event_code)
                    EV_TEMP_OK: begin
                        s.heater = 1'b0; s.chg = 1'b0; s.chg_why = WHY_NONE;
                        s.mode = MODE_CHARGING;
                    end
                    EV_TOO_HOT: begin
                        s.heater = 1'b0; s.chg_why = WHY_HOT; s.mode = MODE_OVERTEMP;
                    end
                    EV_FULL: begin s.heater = 1'b0; s.mode = MODE_CHARGING; end
                    EV_IMBALANCED: a.cmd = CMD_CHARGE;
                    EV_BALANCED: if (held) a.cmd = CMD_RELEASE;
                    EV_CHG_START: a.bad = 1'b1;
                    EV_CHG_END: begin
                        s.heater = 1'b0;
                        if (held && ign) begin
                            s.illegal = 1'b1; s.mode = MODE_ILLEGAL;
                        end else if (empty) begin
                            s.chg = 1'b0; s.chg_why = WHY_NONE; s.mode = MODE_EMPTY;
                        end else begin
                            s.chg = 1'b0; s.chg_why = WHY_NONE;
                            s.drv = 1'b0; s.drv_why = WHY_NONE;
                            s.mode = ign ? MODE_DRIVE : MODE_STANDBY;
                        end
                    end
                    EV_MOD_DEAD: begin
                        s.chg_why = WHY_MODULE; s.drv_why = WHY_MODULE;
                        s.mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        s.chg_why = WHY_SHUNT; s.drv_why = WHY_SHUNT;
                        s.mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_CHARGING: begin
                s.drv = 1'b1; s.drv_why = WHY_CHARGING;
                s.chg = 1'b0; s.chg_why = WHY_NONE; s.heater = 1'b0;
                a.recalc = 1'b1;
                case (i_ev.event_code)
                    EV_TOO_COLD: begin
                        s.heater = 1'b1; s.chg = 1'b1; s.chg_why = WHY_COLD;
                        s.mode = MODE_HEATING;
                    end
                    EV_TOO_HOT: begin s.chg = 1'b1; s.chg_why = WHY_HOT; s.mode = MODE_OVERTEMP; end
                    EV_FULL: begin s.chg = 1'b1; s.chg_why = WHY_FULL; end
                    EV_IMBALANCED: a.cmd = CMD_CHARGE;
                    EV_BALANCED: if (held) a.cmd = CMD_RELEASE;
                    EV_CHG_START: a.bad = 1'b1;
                    EV_CHG_END: begin
                        a.sreset = full;
                        if (held && ign) begin
                            s.chg = 1'b1; s.chg_why = WHY_ILLEGAL;
                            s.illegal = 1'b1; s.mode = MODE_ILLEGAL;
                        end else if (empty) begin
                            s.mode = MODE_EMPTY;
                        end else begin
                            s.drv = 1'b0; s.drv_why = WHY_NONE;
                            s.mode = ign ? MODE_DRIVE : MODE_STANDBY;
                        end
                    end
                    EV_MOD_DEAD: begin
                        s.chg = 1'b1; s.chg_why = WHY_MODULE; s.mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        s.chg = 1'b1; s.chg_why = WHY_SHUNT; s.mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_EMPTY: begin
                s.drv = 1'b1; s.drv_why = WHY_EMPTY; s.heater = 1'b0;
                case (i_ev.event_code)
                    EV_TOO_COLD: begin s.chg = 1'b1; s.chg_why = WHY_COLD; end
                    EV_TEMP_OK: begin s.chg = 1'b0; s.chg_why = WHY_NONE; end
                    EV_TOO_HOT: begin s.chg = 1'b1; s.chg_why = WHY_HOT; s.mode = MODE_OVERTEMP; end
                    EV_NOT_EMPTY, EV_FULL: begin
                        s.drv = 1'b0; s.drv_why = WHY_NONE;
                        if (i_ev.event_code == EV_FULL) begin
                            s.chg = 1'b1; s.chg_why = WHY_FULL;
                        end
                        if (ign) begin
                            s.mode = MODE_DRIVE;
                        end else begin
                            if (imb) a.cmd = CMD_INHIBIT;
                            s.mode = MODE_STANDBY;
                        end
                    end
                    EV_IMBALANCED: if (!ign) a.cmd = CMD_INHIBIT;
                    EV_BALANCED: if (!ign) a.cmd = CMD_RELEASE;
                    EV_IGN_ON: if (imb) a.cmd = CMD_DRIVE;
                    EV_IGN_OFF: if (imb) a.cmd = CMD_INHIBIT;
                    EV_CHG_START: begin
                        if (!ign && imb) a.cmd = CMD_CHARGE;
                        if (cold) begin
                            s.chg = 1'b1; s.chg_why = WHY_COLD; s.heater = 1'b1;
                            s.mode = MODE_HEATING;
                        end else begin
                            s.mode = MODE_CHARGING;
                        end
                    end
                    EV_CHG_END: a.bad = 1'b1;
                    EV_MOD_DEAD: begin
                        s.chg = 1'b1; s.chg_why = WHY_MODULE;
                        s.drv_why = WHY_MODULE; s.mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        s.chg = 1'b1; s.chg_why = WHY_SHUNT;
                        s.drv_why = WHY_SHUNT; s.mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_OVERTEMP: begin
                s.drv = 1'b1; s.drv_why = WHY_HOT;
                s.chg = 1'b1; s.chg_why = WHY_HOT; s.heater = 1'b0;
                a.recalc = 1'b1;
                case (i_ev.event_code)
                    EV_TOO_COLD: begin
                        s.chg_why = WHY_COLD;
                        if (chen) begin
                            s.mode = MODE_HEATING;
                        end else if (ign) begin
                            s.mode = MODE_DRIVE;
                        end else begin
                            if (imb) a.cmd = CMD_INHIBIT;
                            s.mode = MODE_STANDBY;
                        end
                    end
                    EV_TEMP_OK: begin
                        s.chg = 1'b0; s.chg_why = WHY_NONE;
                        if (chen) begin
                            s.mode = MODE_CHARGING;
                        end else begin
                            s.drv = 1'b0; s.drv_why = WHY_NONE;
                            if (ign) begin
                                s.mode = MODE_DRIVE;
                            end else begin
                                if (imb) a.cmd = CMD_INHIBIT;
                                s.mode = MODE_STANDBY;
                            end
                        end
                    end
                    EV_IMBALANCED: if (!ign && !chen) a.cmd = CMD_INHIBIT;
                    EV_BALANCED: if (!ign && !chen) a.cmd = CMD_RELEASE;
                    EV_IGN_ON: if (!chen && imb) a.cmd = CMD_DRIVE;
                    EV_IGN_OFF: if (!chen && imb) a.cmd = CMD_INHIBIT;
                    EV_CHG_START: if (!ign && imb) a.cmd = CMD_CHARGE;
                    EV_CHG_END: if (!ign && imb) a.cmd = CMD_INHIBIT;
                    EV_MOD_DEAD, EV_SHUNT_DEAD: begin
                        if (!ign && !chen) a.cmd = CMD_RELEASE;
                        s.mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_ILLEGAL: begin
                s.drv = 1'b1; s.drv_why = WHY_ILLEGAL;
                s.chg = 1'b1; s.chg_why = WHY_ILLEGAL; s.heater = 1'b0;
                case (i_ev.event_code)
                    EV_IGN_OFF: if (!chen) begin s.illegal = 1'b0; s.mode = MODE_STANDBY; end
                    EV_CHG_END: if (!ign) begin s.illegal = 1'b0; s.mode = MODE_STANDBY; end
                    EV_MOD_DEAD: begin s.chg_why = WHY_MODULE; s.mode = MODE_CRITICAL; end
                    EV_SHUNT_DEAD: begin s.chg_why = WHY_SHUNT; s.mode = MODE_CRITICAL; end
                    default: ;
                endcase
            end
            default: begin
                // Critical fault: leaves only when the failed unit reports back.
                s.drv = 1'b1; s.drv_why = WHY_CRITICAL;
                s.chg = 1'b1; s.chg_why = WHY_CRITICAL; s.heater = 1'b0;
                if ((i_ev.event_code == EV_MODS_OK && !sdead) ||
                    (i_ev.event_code == EV_SHUNT_OK && alive)) begin
                    if (chen) begin
                        s.chg = 1'b0; s.chg_why = WHY_NONE; s.mode = MODE_CHARGING;
                    end else if (ign) begin
                        s.mode = MODE_DRIVE;
                    end else begin
                        if (imb) a.cmd = CMD_INHIBIT;
                        s.mode = MODE_STANDBY;
                    end
                end
            end
        endcase
    end

    assign o_nxt = s;
    assign o_act = a;

endmodule
`default_nettype wire

>>> bench/tb_battery_mode_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery mode controller testbench
// Sends event requests with random status flags through the event channel,
// predicts every result request from a behavioral copy of the mode logic and
// compares each field as results drain, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_battery_mode_controller;
    import bmc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bmc_event_if  ev_ch ();
    bmc_result_if res_ch ();

    battery_mode_controller dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (ev_ch.sink),
        .o_result (res_ch.source)
    );

    // Clock generation.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted controller state.
    logic [2:0]  p_mode;
    logic        p_chg;
    logic [3:0]  p_chg_why;
    logic        p_drv;
    logic [3:0]  p_drv_why;
    logic        p_heat;
    logic        p_illegal;
    logic [15:0] p_bad;

    t_result     expected_results[$];
    int          error_count = 0;
    bit          stall_enable = 1'b1;
    longint      cycle_count = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic set_charge_block(input logic [3:0] why);
        p_chg = 1'b1;
        p_chg_why = why;
    endtask

    task automatic set_drive_block(input logic [3:0] why);
        p_drv = 1'b1;
        p_drv_why = why;
    endtask

    task automatic charge_release();
        p_chg = 1'b0;
        p_chg_why = WHY_NONE;
    endtask

    task automatic drive_release();
        p_drv = 1'b0;
        p_drv_why = WHY_NONE;
    endtask

    // Applies the mode's safety actions, then the event rule, and returns the result.
    task automatic predict_mode_step(input t_event e, output t_result r);
        logic [2:0] cmd;
        logic       weld;
        logic       recalc;
        logic       sreset;
        logic       bad;
        logic       ign;
        logic       chen;
        logic       held;
        logic       imb;
        cmd = CMD_NONE;
        weld = 1'b0;
        recalc = 1'b0;
        sreset = 1'b0;
        bad = 1'b0;
        ign = e.ignition_on;
        chen = e.charge_enabled;
        held = e.contactors_held;
        imb = e.packs_imbalanced;
        case (p_mode)
            MODE_STANDBY: begin
                p_heat = 1'b0;
                weld = 1'b1;
                case (e.event_code)
                    EV_TOO_COLD: set_charge_block(WHY_COLD);
                    EV_TEMP_OK: if (!e.any_cell_full) charge_release();
                    EV_TOO_HOT: begin
                        set_drive_block(WHY_HOT); set_charge_block(WHY_HOT);
                        p_mode = MODE_OVERTEMP;
                    end
                    EV_EMPTY: begin set_drive_block(WHY_EMPTY); p_mode = MODE_EMPTY; end
                    EV_NOT_EMPTY: if (!e.battery_too_hot) charge_release();
                    EV_FULL: set_charge_block(WHY_FULL);
                    EV_IMBALANCED: cmd = CMD_INHIBIT;
                    EV_BALANCED: cmd = CMD_RELEASE;
                    EV_IGN_ON: begin if (held) cmd = CMD_DRIVE; p_mode = MODE_DRIVE; end
                    EV_CHG_START: begin
                        if (held) cmd = CMD_CHARGE;
                        set_drive_block(WHY_CHARGING);
                        if (e.too_cold_for_charge) begin
                            p_heat = 1'b1; set_charge_block(WHY_COLD);
                            p_mode = MODE_HEATING;
                        end else p_mode = MODE_CHARGING;
                    end
                    EV_IGN_OFF, EV_CHG_END: bad = 1'b1;
                    EV_MOD_DEAD: begin
                        set_charge_block(WHY_MODULE); set_drive_block(WHY_MODULE);
                        p_mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        set_charge_block(WHY_SHUNT); set_drive_block(WHY_SHUNT);
                        p_mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_DRIVE: begin
                drive_release();
                p_heat = 1'b0;
                case (e.event_code)
                    EV_TOO_COLD: set_charge_block(WHY_COLD);
                    EV_TEMP_OK: if (!e.any_cell_full) charge_release();
                    EV_TOO_HOT: begin
                        set_drive_block(WHY_HOT); set_charge_block(WHY_HOT);
                        p_mode = MODE_OVERTEMP;
                    end
                    EV_EMPTY: begin set_drive_block(WHY_EMPTY); p_mode = MODE_EMPTY; end
                    EV_NOT_EMPTY: if (!e.too_cold_for_charge) charge_release();
                    EV_FULL: set_charge_block(WHY_FULL);
                    EV_IGN_ON, EV_CHG_END: bad = 1'b1;
                    EV_IGN_OFF: begin if (imb) cmd = CMD_INHIBIT; p_mode = MODE_STANDBY; end
                    EV_CHG_START: begin
                        set_drive_block(WHY_CHARGING);
                        if (held) begin
                            set_charge_block(WHY_ILLEGAL); p_illegal = 1'b1;
                            p_mode = MODE_ILLEGAL;
                        end else p_mode = MODE_CHARGING;
                    end
                    EV_MOD_DEAD: set_charge_block(WHY_MODULE);
                    EV_SHUNT_DEAD: set_charge_block(WHY_SHUNT);
                    default: ;
                endcase
            end
            MODE_HEATING: begin
                set_charge_block(WHY_COLD);
                set_drive_block(WHY_CHARGING);
                p_heat = 1'b1;
                case (e.event_code)
                    EV_TEMP_OK: begin
                        p_heat = 1'b0; charge_release(); p_mode = MODE_CHARGING;
                    end
                    EV_TOO_HOT: begin
                        p_heat = 1'b0; set_charge_block(WHY_HOT); p_mode = MODE_OVERTEMP;
                    end
                    EV_FULL: begin p_heat = 1'b0; p_mode = MODE_CHARGING; end
                    EV_IMBALANCED: cmd = CMD_CHARGE;
                    EV_BALANCED: if (held) cmd = CMD_RELEASE;
                    EV_CHG_START: bad = 1'b1;
                    EV_CHG_END: begin
                        p_heat = 1'b0;
                        if (held && ign) begin
                            p_illegal = 1'b1; p_mode = MODE_ILLEGAL;
                        end else if (e.any_cell_empty) begin
                            charge_release(); p_mode = MODE_EMPTY;
                        end else if (ign) begin
                            charge_release(); drive_release(); p_mode = MODE_DRIVE;
                        end else begin
                            drive_release(); charge_release(); p_mode = MODE_STANDBY;
                        end
                    end
                    EV_MOD_DEAD: begin
                        set_charge_block(WHY_MODULE); set_drive_block(WHY_MODULE);
                        p_mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        set_charge_block(WHY_SHUNT); set_drive_block(WHY_SHUNT);
                        p_mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_CHARGING: begin
                set_drive_block(WHY_CHARGING);
                charge_release();
                p_heat = 1'b0;
                recalc = 1'b1;
                case (e.event_code)
                    EV_TOO_COLD: begin
                        p_heat = 1'b1; set_charge_block(WHY_COLD); p_mode = MODE_HEATING;
                    end
                    EV_TOO_HOT: begin set_charge_block(WHY_HOT); p_mode = MODE_OVERTEMP; end
                    EV_FULL: set_charge_block(WHY_FULL);
                    EV_IMBALANCED: cmd = CMD_CHARGE;
                    EV_BALANCED: if (held) cmd = CMD_RELEASE;
                    EV_CHG_START: bad = 1'b1;
                    EV_CHG_END: begin
                        if (e.any_cell_full) sreset = 1'b1;
                        if (held && ign) begin
                            set_charge_block(WHY_ILLEGAL); p_illegal = 1'b1;
                            p_mode = MODE_ILLEGAL;
                        end else if (e.any_cell_empty) p_mode = MODE_EMPTY;
                        else if (ign) begin drive_release(); p_mode = MODE_DRIVE; end
                        else begin drive_release(); p_mode = MODE_STANDBY; end
                    end
                    EV_MOD_DEAD: begin
                        set_charge_block(WHY_MODULE); p_mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        set_charge_block(WHY_SHUNT); p_mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_EMPTY: begin
                set_drive_block(WHY_EMPTY);
                p_heat = 1'b0;
                case (e.event_code)
                    EV_TOO_COLD: set_charge_block(WHY_COLD);
                    EV_TEMP_OK: charge_release();
                    EV_TOO_HOT: begin set_charge_block(WHY_HOT); p_mode = MODE_OVERTEMP; end
                    EV_NOT_EMPTY, EV_FULL: begin
                        drive_release();
                        if (e.event_code == EV_FULL) set_charge_block(WHY_FULL);
                        if (ign) p_mode = MODE_DRIVE;
                        else begin if (imb) cmd = CMD_INHIBIT; p_mode = MODE_STANDBY; end
                    end
                    EV_IMBALANCED: if (!ign) cmd = CMD_INHIBIT;
                    EV_BALANCED: if (!ign) cmd = CMD_RELEASE;
                    EV_IGN_ON: if (imb) cmd = CMD_DRIVE;
                    EV_IGN_OFF: if (imb) cmd = CMD_INHIBIT;
                    EV_CHG_START: begin
                        if (!ign && imb) cmd = CMD_CHARGE;
                        if (e.too_cold_for_charge) begin
                            set_charge_block(WHY_COLD); p_heat = 1'b1; p_mode = MODE_HEATING;
                        end else p_mode = MODE_CHARGING;
                    end
                    EV_CHG_END: bad = 1'b1;
                    EV_MOD_DEAD: begin
                        set_charge_block(WHY_MODULE); set_drive_block(WHY_MODULE);
                        p_mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        set_charge_block(WHY_SHUNT); set_drive_block(WHY_SHUNT);
                        p_mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_OVERTEMP: begin
                set_drive_block(WHY_HOT);
                set_charge_block(WHY_HOT);
                p_heat = 1'b0;
                recalc = 1'b1;
                case (e.event_code)
                    EV_TOO_COLD: begin
                        set_charge_block(WHY_COLD);
                        if (chen) p_mode = MODE_HEATING;
                        else if (ign) p_mode = MODE_DRIVE;
                        else begin if (imb) cmd = CMD_INHIBIT; p_mode = MODE_STANDBY; end
                    end
                    EV_TEMP_OK: begin
                        if (chen) begin charge_release(); p_mode = MODE_CHARGING; end
                        else if (ign) begin
                            charge_release(); drive_release(); p_mode = MODE_DRIVE;
                        end else begin
                            drive_release(); charge_release();
                            if (imb) cmd = CMD_INHIBIT;
                            p_mode = MODE_STANDBY;
                        end
                    end
                    EV_IMBALANCED: if (!ign && !chen) cmd = CMD_INHIBIT;
                    EV_BALANCED: if (!ign && !chen) cmd = CMD_RELEASE;
                    EV_IGN_ON: if (!chen && imb) cmd = CMD_DRIVE;
                    EV_IGN_OFF: if (!chen && imb) cmd = CMD_INHIBIT;
                    EV_CHG_START: if (!ign && imb) cmd = CMD_CHARGE;
                    EV_CHG_END: if (!ign && imb) cmd = CMD_INHIBIT;
                    EV_MOD_DEAD, EV_SHUNT_DEAD: begin
                        if (!ign && !chen) cmd = CMD_RELEASE;
                        p_mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            MODE_ILLEGAL: begin
                set_drive_block(WHY_ILLEGAL);
                set_charge_block(WHY_ILLEGAL);
                p_heat = 1'b0;
                case (e.event_code)
                    EV_IGN_OFF: if (!chen) begin p_illegal = 1'b0; p_mode = MODE_STANDBY; end
                    EV_CHG_END: if (!ign) begin p_illegal = 1'b0; p_mode = MODE_STANDBY; end
                    EV_MOD_DEAD: begin
                        set_charge_block(WHY_MODULE); p_mode = MODE_CRITICAL;
                    end
                    EV_SHUNT_DEAD: begin
                        set_charge_block(WHY_SHUNT); p_mode = MODE_CRITICAL;
                    end
                    default: ;
                endcase
            end
            default: begin
                set_drive_block(WHY_CRITICAL);
                set_charge_block(WHY_CRITICAL);
                p_heat = 1'b0;
                if ((e.event_code == EV_MODS_OK && !e.shunt_dead) ||
                    (e.event_code == EV_SHUNT_OK && e.modules_alive)) begin
                    if (chen) begin charge_release(); p_mode = MODE_CHARGING; end
                    else if (ign) p_mode = MODE_DRIVE;
                    else begin if (imb) cmd = CMD_INHIBIT; p_mode = MODE_STANDBY; end
                end
            end
        endcase
        // Invalid events saturate at the counter's top value.
        if (bad && p_bad != 16'hFFFF) p_bad = p_bad + 16'd1;
        r.mode = p_mode;
        r.charge_block = p_chg;
        r.charge_block_why = p_chg_why;
        r.drive_block = p_drv;
        r.drive_block_why = p_drv_why;
        r.heater_drive = p_heat;
        r.contactor_cmd = cmd;
        r.weld_check_pulse = weld;
        r.limit_recalc_pulse = recalc;
        r.shunt_reset_pulse = sreset;
        r.illegal_flag = p_illegal;
        r.bad_event_count = p_bad;
    endtask

    // Sends one event request, sometimes with a random gap first, and queues its prediction.
    task automatic send_event(input t_event e);
        t_result r;
        int gap;
        if (stall_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.data <= e;
        @(posedge i_clk);
        while (!ev_ch.ready) @(posedge i_clk);
        predict_mode_step(e, r);
        expected_results.push_back(r);
    endtask

    // Drops valid and syncs to the clock so the next request starts cleanly.
    task automatic release_channel();
        ev_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_event random_event();
        t_event e;
        e = t_event'($urandom_range(0, 16383));
        return e;
    endfunction

    function automatic t_event make_event(input logic [3:0] code, input logic [9:0] flags);
        t_event e;
        e = {code, flags};
        return e;
    endfunction

    // Directed: every event code, flag extremes, and counter increment.
    task automatic test_directed_events();
        for (int i = 0; i < 16; i++) begin
            send_event(make_event(i[3:0], (i % 2) ? 10'h3FF : 10'h000));
            // Return from critical mode to standby if that event led there.
            send_event(make_event(EV_MODS_OK, 10'h000));
        end
        send_event(make_event(EV_CHG_END, 10'h000));
        send_event(make_event(EV_IGN_OFF, 10'h3FF));
        release_channel();
    endtask

    // Walks well-formed sequences through every mode with random flags.
    task automatic test_mode_walks();
        logic [3:0] path [0:7];
        t_event e;
        for (int n = 0; n < 60; n++) begin
            path[0] = EV_CHG_START;
            path[1] = ($urandom_range(0, 1)) ? EV_TOO_COLD : EV_TEMP_OK;
            path[2] = ($urandom_range(0, 1)) ? EV_TOO_HOT : EV_FULL;
            path[3] = ($urandom_range(0, 1)) ? EV_TEMP_OK : EV_TOO_COLD;
            path[4] = ($urandom_range(0, 1)) ? EV_CHG_END : EV_EMPTY;
            path[5] = ($urandom_range(0, 1)) ? EV_MOD_DEAD : EV_SHUNT_DEAD;
            path[6] = ($urandom_range(0, 1)) ? EV_MODS_OK : EV_SHUNT_OK;
            path[7] = ($urandom_range(0, 1)) ? EV_IGN_OFF : EV_CHG_END;
            for (int k = 0; k < 8; k++) begin
                e = random_event();
                if ($urandom_range(0, 5) != 0) e.event_code = path[k];
                send_event(e);
            end
        end
        release_channel();
    endtask

    // Pure random events, the last part without any stalls.
    task automatic test_random_events();
        for (int n = 0; n < 80; n++) begin
            if (n == 40) stall_enable = 1'b0;
            send_event(random_event());
        end
        release_channel();
    endtask

    // Result checking with random receiver stalls.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result count", 16'd1, 16'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.mode !== want.mode)
                    report_mismatch("mode", 16'(got.mode), 16'(want.mode));
                if (got.charge_block !== want.charge_block)
                    report_mismatch("charge_block", 16'(got.charge_block),
                                    16'(want.charge_block));
                if (got.charge_block_why !== want.charge_block_why)
                    report_mismatch("charge_block_why", 16'(got.charge_block_why),
                                    16'(want.charge_block_why));
                if (got.drive_block !== want.drive_block)
                    report_mismatch("drive_block", 16'(got.drive_block),
                                    16'(want.drive_block));
                if (got.drive_block_why !== want.drive_block_why)
                    report_mismatch("drive_block_why", 16'(got.drive_block_why),
                                    16'(want.drive_block_why));
                if (got.heater_drive !== want.heater_drive)
                    report_mismatch("heater_drive", 16'(got.heater_drive),
                                    16'(want.heater_drive));
                if (got.contactor_cmd !== want.contactor_cmd)
                    report_mismatch("contactor_cmd", 16'(got.contactor_cmd),
                                    16'(want.contactor_cmd));
                if (got.weld_check_pulse !== want.weld_check_pulse)
                    report_mismatch("weld_check_pulse", 16'(got.weld_check_pulse),
                                    16'(want.weld_check_pulse));
                if (got.limit_recalc_pulse !== want.limit_recalc_pulse)
                    report_mismatch("limit_recalc_pulse", 16'(got.limit_recalc_pulse),
                                    16'(want.limit_recalc_pulse));
                if (got.shunt_reset_pulse !== want.shunt_reset_pulse)
                    report_mismatch("shunt_reset_pulse", 16'(got.shunt_reset_pulse),
                                    16'(want.shunt_reset_pulse));
                if (got.illegal_flag !== want.illegal_flag)
                    report_mismatch("illegal_flag", 16'(got.illegal_flag),
                                    16'(want.illegal_flag));
                if (got.bad_event_count !== want.bad_event_count)
                    report_mismatch("bad_event_count", got.bad_event_count,
                                    want.bad_event_count);
            end
        end
    end

    // Random receiver stall bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!stall_enable) begin
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 9);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        if (cycle_count > 200000) begin
            $display("battery_mode_controller test failed");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        ev_ch.valid = 1'b0;
        ev_ch.data = '0;
        p_mode = MODE_STANDBY;
        p_chg = 1'b0;
        p_chg_why = WHY_NONE;
        p_drv = 1'b0;
        p_drv_why = WHY_NONE;
        p_heat = 1'b0;
        p_illegal = 1'b0;
        p_bad = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_events();
        test_mode_walks();
        test_random_events();
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("battery_mode_controller test passed");
        end else begin
            $display("battery_mode_controller test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
